// ===== hw/rtl/art_pkg.sv =====
// Shared types and constants for the address range table.
// Used by art_match, art_seq, the top module and the testbench; depends on nothing.
`default_nettype none

package art_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Operation codes of the func input field.
    typedef enum logic [1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_UNREGISTER = 2'd1,
        FUNC_LOOKUP     = 2'd2
    } t_func;

    // One stored range, as it sits in one RAM word.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result word.
    typedef struct packed {
        logic        hit;
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] tag;
        logic [31:0] offset;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_SRCH,
        S_DEL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/art_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module art_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/art_match.sv =====
// Containment check of one address against one stored range.
// Depends on art_pkg for the entry type.
`default_nettype none

module art_match
    import art_pkg::*;
(
    input  wire t_entry      i_entry,
    input  wire logic [31:0] i_address,
    output logic             o_hit
);

    logic [32:0] range_end;

    // The end is formed in 33 bits so that a range reaching the top of the
    // address space does not wrap around.
    assign range_end = {1'b0, i_entry.base} + {1'b0, i_entry.len};
    assign o_hit = (i_entry.base <= i_address) && (range_end > {1'b0, i_address});

endmodule

`default_nettype wire

// ===== hw/rtl/art_seq.sv =====
// Sequencer of the address range table: walks the range RAM one entry per
// cycle to search, shift-insert and shift-delete. Depends on art_pkg, art_match.
`default_nettype none

module art_seq
    import art_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [31:0]       i_address,
    input  wire logic [31:0]       i_range_size,
    input  wire logic [31:0]       i_user_tag,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    output logic      [CNT_W-1:0]  o_used,
    output logic      [IDX_W-1:0]  o_rd_addr,
    input  wire t_entry            i_rd_data,
    output logic                   o_wr_en,
    output logic      [IDX_W-1:0]  o_wr_addr,
    output t_entry                 o_wr_data
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [1:0]        r_func, n_func;
    logic [31:0]       r_addr, n_addr;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_tag, n_tag;
    t_result           r_res, n_res;

    t_entry            new_entry;
    logic              rd_hit;
    logic [CNT_W-1:0]  idx_next_cnt;
    logic              at_last;

    art_match u_match (
        .i_entry   (i_rd_data),
        .i_address (r_addr),
        .o_hit     (rd_hit)
    );

    assign new_entry    = '{base: r_addr, len: r_size, tag: r_tag};
    assign idx_next_cnt = CNT_W'(r_idx) + CNT_W'(1);
    assign at_last      = (idx_next_cnt == r_used);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_used    = r_used;
        n_func    = r_func;
        n_addr    = r_addr;
        n_size    = r_size;
        n_tag     = r_tag;
        n_res     = r_res;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_func;
                    n_addr = i_address;
                    n_size = i_range_size;
                    n_tag  = i_user_tag;
                    n_res  = '0;
                    unique case (i_func) inside
                        FUNC_REGISTER: begin
                            if (r_used == CNT_W'(TABLE_DEPTH)) begin
                                n_state = S_DONE;
                            end else if (r_used == '0) begin
                                n_idx   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_idx   = IDX_W'(r_used - CNT_W'(1));
                                n_state = S_INS;
                            end
                        end
                        FUNC_UNREGISTER, FUNC_LOOKUP: begin
                            if (r_used == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                // Walk down from the top, moving larger bases up by one slot.
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx + IDX_W'(1);
                if (i_rd_data.base > r_addr) begin
                    o_wr_data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end else begin
                    o_wr_data = new_entry;
                    n_res.hit = 1'b1;
                    n_used    = r_used + CNT_W'(1);
                    n_state   = S_DONE;
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = new_entry;
                n_res.hit = 1'b1;
                n_used    = r_used + CNT_W'(1);
                n_state   = S_DONE;
            end
            S_SRCH: begin
                if (rd_hit) begin
                    n_res.hit  = 1'b1;
                    n_res.base = i_rd_data.base;
                    n_res.size = i_rd_data.len;
                    n_res.tag  = i_rd_data.tag;
                    if (r_func == FUNC_LOOKUP) begin
                        n_res.offset = r_addr - i_rd_data.base;
                        n_state      = S_DONE;
                    end else if (at_last) begin
                        n_used  = r_used - CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_DEL;
                    end
                end else if (at_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DEL: begin
                // Close the gap: each later entry moves down by one slot.
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx - IDX_W'(1);
                o_wr_data = i_rd_data;
                if (at_last) begin
                    n_used  = r_used - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_func <= n_func;
        r_addr <= n_addr;
        r_size <= n_size;
        r_tag  <= n_tag;
        r_res  <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_used      = r_used;
    assign o_rd_addr   = n_idx;

endmodule

`default_nettype wire

// ===== hw/rtl/address_range_table_top.sv =====
// Address range table: a sorted table of up to TABLE_DEPTH ranges (base, size,
// tag) held in one RAM word per range. Register inserts a range after all
// entries of equal base and is refused with hit 0 when the table is full;
// unregister removes the first range, in ascending base order, that contains
// the address; lookup reports the first containing range and the offset of
// the address within it. Containment uses a 33-bit end, so no range wraps.
// One word is worked at a time, and the cost is set by the single RAM read
// port, which the sequencer walks one entry per cycle. A register walks down
// from the top past the entries of larger base (none when the table is empty
// or full); a lookup that hits walks up to the hit, and an unregister or a
// lookup that misses walks every stored entry. The result sits in an output
// register, so a new word is taken while the last result still waits on the
// output side. The RAM needs no clearing pass: only entries below the fill
// count are ever read.
// Depends on art_pkg, art_ram, art_match and art_seq.
`default_nettype none

module address_range_table_top
    import art_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_range_size,
    input  wire logic [31:0] i_user_tag,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_hit,
    output logic [31:0]      o_region_base,
    output logic [31:0]      o_region_size,
    output logic [31:0]      o_region_tag,
    output logic [31:0]      o_offset
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer to RAM and to output stage.
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic [CNT_W-1:0] used;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // Output register.
    logic             r_out_valid;
    t_result          r_out;

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    art_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_range_size (i_range_size),
        .i_user_tag   (i_user_tag),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_used       (used),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_region_base = r_out.base;
    assign o_region_size = r_out.size;
    assign o_region_tag  = r_out.tag;
    assign o_offset      = r_out.offset;

    // Only one word is in flight: after a word is taken the input closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is still in progress");

    // The fill count never exceeds the table depth.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A handed-off result always reaches the output register.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> (o_out_valid && (r_out == $past(res))))
        else $error("result lost between sequencer and output register");

    // A miss carries all-zero fields.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_region_base == '0 && o_region_size == '0
            && o_region_tag == '0 && o_offset == '0))
        else $error("miss result with nonzero fields");

endmodule

`default_nettype wire

// ===== verif/address_range_table_top_tb.sv =====
// Self-checking testbench for address_range_table_top: a shadow copy of the
// range table predicts every result word, which is checked against the block.
// Depends on art_pkg and the address_range_table_top RTL.
`default_nettype none

module address_range_table_top_tb;

    import art_pkg::*;

    // The depth that the block is built with, and the one code that the
    // func field can carry without naming an operation.
    localparam int         DEPTH        = DEPTH_DEFAULT;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    // Roughly 850 real operations in the random part. The watchdog limit covers
    // the slowest unregister, the longest sender gap, and a long stretch of
    // output stalls, all taken many times over.
    localparam int RANDOM_WORDS = 850;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 4 * (DEPTH + 3);

    // Mixes of operations for the random part. Fill mostly registers, so the
    // table reaches the full state; drain mostly unregisters, so it empties.
    typedef enum int {
        MIX_FILL,
        MIX_MIXED,
        MIX_DRAIN
    } t_mix;

    // Shadow of the range table. It applies each accepted word to its own copy
    // of the table, queues the result that word must produce, and compares the
    // result words of the block against that queue in order.
    class range_table_shadow;
        logic [31:0] base_q[DEPTH];
        logic [31:0] len_q[DEPTH];
        logic [31:0] tag_q[DEPTH];
        int          fill;
        t_result     awaited_results[$];
        int          errors;
        int          results_seen;

        function new();
            fill         = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Apply one operation to the table copy and return its result word.
        function t_result apply_range_op(logic [1:0] f, logic [31:0] a,
                                         logic [31:0] s, logic [31:0] t);
            t_result     r;
            int          pos;
            int          j;
            logic [32:0] span_end;
            r = '0;
            if (f == FUNC_REGISTER) begin
                if (fill < DEPTH) begin
                    // Insert after every entry whose base is not above a.
                    pos = 0;
                    while (pos < fill && base_q[pos] <= a) pos++;
                    for (j = fill; j > pos; j--) begin
                        base_q[j] = base_q[j - 1];
                        len_q[j]  = len_q[j - 1];
                        tag_q[j]  = tag_q[j - 1];
                    end
                    base_q[pos] = a;
                    len_q[pos]  = s;
                    tag_q[pos]  = t;
                    fill++;
                    r.hit = 1'b1;
                end
            end else if (f == FUNC_UNREGISTER || f == FUNC_LOOKUP) begin
                // The end of a range is taken in 33 bits, so it never wraps.
                pos = fill;
                for (j = 0; j < fill; j++) begin
                    span_end = {1'b0, base_q[j]} + {1'b0, len_q[j]};
                    if (base_q[j] <= a && span_end > {1'b0, a}) begin
                        pos = j;
                        break;
                    end
                end
                if (pos < fill) begin
                    r.hit  = 1'b1;
                    r.base = base_q[pos];
                    r.size = len_q[pos];
                    r.tag  = tag_q[pos];
                    if (f == FUNC_LOOKUP) begin
                        r.offset = a - base_q[pos];
                    end else begin
                        for (j = pos; j + 1 < fill; j++) begin
                            base_q[j] = base_q[j + 1];
                            len_q[j]  = len_q[j + 1];
                            tag_q[j]  = tag_q[j + 1];
                        end
                        fill--;
                    end
                end
            end
            return r;
        endfunction

        function void note_word(logic [1:0] f, logic [31:0] a,
                                logic [31:0] s, logic [31:0] t);
            awaited_results.push_back(apply_range_op(f, a, s, t));
        endfunction

        task report(string msg);
            $display("%s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %h, expected %h",
                                 results_seen, name, got, want));
        endtask

        task check_word(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %0d: no word expected, got hit %b base %h",
                                 results_seen, got.hit, got.base));
            end else begin
                want = awaited_results.pop_front();
                compare_field("hit", {31'd0, got.hit}, {31'd0, want.hit});
                compare_field("region_base", got.base, want.base);
                compare_field("region_size", got.size, want.size);
                compare_field("region_tag", got.tag, want.tag);
                compare_field("offset", got.offset, want.offset);
            end
            results_seen++;
        endtask
    endclass

    // Every input starts at a known value; reset is held low from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_func       = '0;
    logic [31:0] i_address    = '0;
    logic [31:0] i_range_size = '0;
    logic [31:0] i_user_tag   = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_hit;
    logic [31:0] o_region_base;
    logic [31:0] o_region_size;
    logic [31:0] o_region_tag;
    logic [31:0] o_offset;

    range_table_shadow sb = new();

    address_range_table_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_range_size  (i_range_size),
        .i_user_tag    (i_user_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_region_base (o_region_base),
        .o_region_size (o_region_size),
        .o_region_tag  (o_region_tag),
        .o_offset      (o_offset)
    );

    always #10 i_clk = ~i_clk;

    // The sender works in bursts. When a burst ends, valid drops for a random
    // gap; now and then a long burst runs with no gap at all.
    int burst_left = 0;

    // Offer one word and hold it until the block takes it. The task is always
    // entered right after a rising edge, so the handshake seen at each later
    // edge is the one that edge completes.
    task issue_word(logic [1:0] f, logic [31:0] a, logic [31:0] s, logic [31:0] t);
        int gap;
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_address    <= a;
        i_range_size <= s;
        i_user_tag   <= t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(f, a, s, t);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Base for a new range. Half the bases fall in a small window so that ranges
    // overlap and probes find them; some repeat a stored base, and some sit
    // near the top of the address space.
    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return (sb.fill > 0) ? sb.base_q[$urandom_range(0, sb.fill - 1)] : $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 'hFFF);
            default: return $urandom_range(0, 'hFFFF);
        endcase
    endfunction

    // Size for a new range. A zero-size range can never be removed, so only a
    // few of them are let into the table at once; otherwise they would clog it.
    function automatic logic [31:0] pick_size();
        int zeros;
        zeros = 0;
        for (int i = 0; i < sb.fill; i++) if (sb.len_q[i] == 0) zeros++;
        case ($urandom_range(0, 9))
            0: return (zeros < 2) ? 32'd0 : 32'd1;
            1: return $urandom;
            2, 3: return $urandom_range(1, 256);
            4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom_range(1, 'h10000);
        endcase
    endfunction

    // Probe address for lookup and unregister: mostly inside a stored range,
    // else at its first address, just past its end, just below its base, or
    // anywhere at all.
    function automatic logic [31:0] pick_probe();
        int          k;
        logic [31:0] b;
        logic [31:0] l;
        if (sb.fill == 0 || $urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 'hFFFF);
        k = $urandom_range(0, sb.fill - 1);
        b = sb.base_q[k];
        l = sb.len_q[k];
        case ($urandom_range(0, 5))
            0, 1, 2: return (l == 0) ? b : b + ($urandom % l);
            3: return b + l;
            4: return b - 1;
            default: return b;
        endcase
    endfunction

    // Output side: result words are checked at the edge that accepts them.
    // Ready follows a stall pattern of its own, whose mode is drawn anew when a
    // random stretch ends: always ready, coin toss, rarely ready, or a fixed beat.
    t_result seen_word;
    int      stall_mode = 0;
    int      stall_left = 0;
    int      beat       = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_word.hit    = o_hit;
            seen_word.base   = o_region_base;
            seen_word.size   = o_region_size;
            seen_word.tag    = o_region_tag;
            seen_word.offset = o_offset;
            sb.check_word(seen_word);
        end
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        beat <= (beat == 4) ? 0 : beat + 1;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= (beat < 2);
        endcase
    end

    // Watchdog: too many cycles in a row with no word moving on either side
    // means the block has hung.
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("address_range_table_top_tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        t_mix        mix;
        int          mix_idx;
        int          mix_left;
        int          items;
        int          roll;
        int          reg_cut;
        int          look_cut;
        logic [1:0]  f;
        logic [31:0] a;
        logic [31:0] s;
        logic [31:0] t;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table misses everything, and the unused
        // code does nothing.
        issue_word(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        issue_word(FUNC_UNREGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_word(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A range covering all but the top address, one at the top address
        // whose end lies past 32 bits, a zero-size range, and a second range
        // at base zero that must land after the first one.
        issue_word(FUNC_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_word(FUNC_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_word(FUNC_REGISTER, 32'h0000_1000, 32'h0000_0000, 32'hA5A5_A5A5);
        issue_word(FUNC_REGISTER, 32'h0000_0000, 32'h0000_0010, 32'h0000_0001);
        // Overlaps: the first range in base order wins, the zero-size range
        // never matches, and the top address falls only in the last range.
        issue_word(FUNC_LOOKUP, 32'h0000_1000, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        // Removing the wide range exposes the small one at the same base.
        issue_word(FUNC_UNREGISTER, 32'h0000_0005, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'h0000_0005, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'h0000_1000, 32'h0, 32'h0);
        issue_word(FUNC_UNUSED, 32'h0, 32'h0, 32'h0);
        issue_word(FUNC_UNREGISTER, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue_word(FUNC_UNREGISTER, 32'h0000_0008, 32'h0, 32'h0);
        issue_word(FUNC_LOOKUP, 32'h0000_1000, 32'h0, 32'h0);
        issue_word(FUNC_UNREGISTER, 32'h0000_1000, 32'h0, 32'h0);

        // Random part: mixes rotate fill, mixed, drain so the table is driven
        // to full (and refusals) and back toward empty many times over.
        items    = 0;
        mix_idx  = 0;
        mix_left = 0;
        mix      = MIX_FILL;
        while (items < RANDOM_WORDS) begin
            if (mix_left == 0) begin
                mix      = t_mix'(mix_idx % 3);
                mix_idx  = mix_idx + 1;
                mix_left = $urandom_range(30, 80);
            end
            mix_left--;
            case (mix)
                MIX_FILL: begin
                    reg_cut  = 65;
                    look_cut = 85;
                end
                MIX_DRAIN: begin
                    reg_cut  = 15;
                    look_cut = 40;
                end
                default: begin
                    reg_cut  = 35;
                    look_cut = 70;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < reg_cut)       f = FUNC_REGISTER;
            else if (roll < look_cut) f = FUNC_LOOKUP;
            else if (roll < 97)       f = FUNC_UNREGISTER;
            else                      f = FUNC_UNUSED;
            // Size and tag ride along as noise on probes and unused codes.
            a = (f == FUNC_REGISTER) ? pick_base() : pick_probe();
            s = (f == FUNC_REGISTER) ? pick_size() : $urandom;
            t = $urandom;
            issue_word(f, a, s, t);
            if (f != FUNC_UNUSED) items++;
        end
        i_in_valid <= 1'b0;

        // Wait for every awaited result, then a little longer so that any
        // stray word from the block would still be caught.
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.awaited_results.size() != 0)
            sb.report($sformatf("%0d result words never arrived",
                                sb.awaited_results.size()));

        if (sb.errors == 0) begin
            $display("address_range_table_top_tb: done, clean");
        end else begin
            $display("address_range_table_top_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/art_pkg.sv
hw/rtl/art_ram.sv
hw/rtl/art_match.sv
hw/rtl/art_seq.sv
hw/rtl/address_range_table_top.sv
verif/address_range_table_top_tb.sv
